// ----- rtl/bnp_pkg.sv -----
// Shared types and constants for the bump-map normal perturbation pipeline.
// Used by bump_normal_perturb and tb_top; depends on nothing else.
package bnp_pkg;

  // Request and result payloads.
  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [15:0] texel_r;
    logic        [15:0] texel_g;
    logic        [15:0] texel_b;
  } req_t;

  typedef struct packed {
    logic signed [15:0] bent_x;
    logic signed [15:0] bent_y;
    logic signed [15:0] bent_z;
    logic               degenerate;
  } rsp_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GAIN_X = 2'd0,
    REG_GAIN_Y = 2'd1,
    REG_GAIN_Z = 2'd2
  } reg_idx_t;

  // Per-request sideband carried along the pipeline.
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               zero;
    logic               neg;
    logic        [2:0]  sgn;
  } side_t;

  localparam logic signed [15:0] GAIN_RESET = 16'sd4096;
  localparam logic signed [16:0] HALF_TEXEL = 17'sd32768;
  localparam int NORM_ALIGN  = 13;
  localparam int UNIT_SHIFT  = 14;
  localparam int SHIFT_STEPS = 5;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 15;
  // Register stages from request to result.
  localparam int LATENCY = 3 + SHIFT_STEPS + 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;

endpackage

// ----- rtl/bump_normal_perturb.sv -----
// Bump-map normal perturbation: fully pipelined, one request per clock.
// Depends on bnp_pkg for payload types, register indexes and stage counts.
//
// Usage: a request (normal plus bump texel) is taken at each rising edge where
// start is high and busy is low. busy is always low: the pipeline has no
// stalls and accepts a new request in every cycle. The result of a request
// appears on rsp for one cycle, marked by done.
// The receiver cannot hold results off, so none is ever needed.
// The latency is set by the digit-by-digit square root (32 stages, one root
// bit each) and the restoring dividers (15 stages, one quotient bit each),
// plus the front end: gain multiply, dot product, max search, a 5-stage
// normalizing shifter, squares and their sum, and the result register.
// Gains are written through cfg_we/cfg_index/cfg_data at any edge; writes to
// an index beyond the three gains are dropped. A write takes effect for
// requests accepted after it.
// Reset (rst, synchronous) sets all gains to 1.0 and clears every valid bit
// in flight, so no stale result leaves after reset.
module bump_normal_perturb
  import bnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic signed [15:0] gain [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain[0] <= GAIN_RESET;
      gain[1] <= GAIN_RESET;
      gain[2] <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_X: gain[0] <= cfg_data;
        REG_GAIN_Y: gain[1] <= cfg_data;
        REG_GAIN_Z: gain[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Valid bits travel down a shift chain alongside the data stages.
  logic [LATENCY-1:0] vld;
  logic               accept;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  // Stage A: perturbed sum in units of 2^-27, S = n * 2^13 + g * (t - 32768).
  logic signed [15:0] in_n [0:2];
  logic        [15:0] in_t [0:2];
  logic signed [31:0] a_s  [0:2];
  side_t              a_side;

  assign in_n[0] = req.normal_x;
  assign in_n[1] = req.normal_y;
  assign in_n[2] = req.normal_z;
  assign in_t[0] = req.texel_r;
  assign in_t[1] = req.texel_g;
  assign in_t[2] = req.texel_b;

  for (genvar i = 0; i < 3; i++) begin : g_sum
    logic signed [16:0] tc;
    logic signed [32:0] prod;
    logic signed [32:0] sum;
    assign tc   = $signed({1'b0, in_t[i]}) - HALF_TEXEL;
    assign prod = gain[i] * tc;
    assign sum  = (33'(in_n[i]) <<< NORM_ALIGN) + prod;
    always_ff @(posedge clk) begin
      a_s[i] <= sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    a_side.nx   <= req.normal_x;
    a_side.ny   <= req.normal_y;
    a_side.nz   <= req.normal_z;
    a_side.zero <= 1'b0;
    a_side.neg  <= 1'b0;
    a_side.sgn  <= '0;
  end

  // Stage B: magnitudes, signs, zero test and the dot product terms.
  logic [30:0]        b_a [0:2];
  logic signed [47:0] b_p [0:2];
  side_t              b_side;
  side_t              b_side_next;
  logic signed [15:0] a_n [0:2];

  assign a_n[0] = a_side.nx;
  assign a_n[1] = a_side.ny;
  assign a_n[2] = a_side.nz;

  for (genvar i = 0; i < 3; i++) begin : g_abs
    logic [31:0] mag;
    assign mag = a_s[i][31] ? 32'(-a_s[i]) : 32'(a_s[i]);
    always_ff @(posedge clk) begin
      b_a[i] <= mag[30:0];
      b_p[i] <= a_s[i] * a_n[i];
    end
  end

  always_comb begin
    b_side_next      = a_side;
    b_side_next.zero = (a_s[0] == '0) && (a_s[1] == '0) && (a_s[2] == '0);
    b_side_next.sgn  = {a_s[2][31], a_s[1][31], a_s[0][31]};
  end

  always_ff @(posedge clk) begin
    b_side <= b_side_next;
  end

  // Stage C: sign of the dot product and the largest magnitude.
  logic [30:0]        sh_m    [0:SHIFT_STEPS];
  logic [30:0]        sh_a    [0:SHIFT_STEPS][0:2];
  side_t              sh_side [0:SHIFT_STEPS];
  side_t              sh_side_next;
  logic signed [49:0] dot;
  logic [30:0]        m01;

  assign dot = 50'(b_p[0]) + 50'(b_p[1]) + 50'(b_p[2]);
  assign m01 = (b_a[1] > b_a[0]) ? b_a[1] : b_a[0];

  always_comb begin
    sh_side_next     = b_side;
    sh_side_next.neg = dot[49];
  end

  always_ff @(posedge clk) begin
    sh_m[0]    <= (b_a[2] > m01) ? b_a[2] : m01;
    sh_a[0]    <= b_a;
    sh_side[0] <= sh_side_next;
  end

  // Normalizing shifter: scale up by 16, 8, 4, 2, 1 until the largest
  // magnitude has bit 30 set. Direction is kept since all three move together.
  for (genvar j = 0; j < SHIFT_STEPS; j++) begin : g_shift
    localparam int W = 16 >> j;
    logic hit;
    assign hit = (sh_m[j][30 -: W] == '0);
    always_ff @(posedge clk) begin
      sh_side[j+1] <= sh_side[j];
      sh_m[j+1]    <= hit ? (sh_m[j] << W) : sh_m[j];
      for (int i = 0; i < 3; i++) begin
        sh_a[j+1][i] <= hit ? (sh_a[j][i] << W) : sh_a[j][i];
      end
    end
  end

  // Stage E: squares. Stage F: their 64-bit sum.
  logic [61:0] e_sq [0:2];
  logic [30:0] e_a  [0:2];
  side_t       e_side;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e_sq[i] <= sh_a[SHIFT_STEPS][i] * sh_a[SHIFT_STEPS][i];
      e_a[i]  <= sh_a[SHIFT_STEPS][i];
    end
    e_side <= sh_side[SHIFT_STEPS];
  end

  // Square root pipeline, index 0 holds the sum of squares.
  logic [63:0] sq_q    [0:SQRT_STEPS];
  logic [33:0] sq_rem  [0:SQRT_STEPS];
  logic [31:0] sq_root [0:SQRT_STEPS];
  logic [30:0] sq_a    [0:SQRT_STEPS][0:2];
  side_t       sq_side [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    sq_q[0]    <= 64'(e_sq[0]) + 64'(e_sq[1]) + 64'(e_sq[2]);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_a[0]    <= e_a;
    sq_side[0] <= e_side;
  end

  // One root bit per stage: bring down two radicand bits, try 4r+1.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        fit;
    logic [35:0] diff;
    assign rem_sh = {sq_rem[k], sq_q[k][63:62]};
    assign trial  = {2'b00, sq_root[k], 2'b01};
    assign fit    = (rem_sh >= trial);
    assign diff   = rem_sh - trial;
    always_ff @(posedge clk) begin
      sq_q[k+1]    <= sq_q[k] << 2;
      sq_rem[k+1]  <= fit ? diff[33:0] : rem_sh[33:0];
      sq_root[k+1] <= {sq_root[k][30:0], fit};
      sq_a[k+1]    <= sq_a[k];
      sq_side[k+1] <= sq_side[k];
    end
  end

  // Divider setup: numerator a * 2^14 + floor(L / 2) for each component.
  logic [45:0] dv_pr  [0:DIV_STEPS][0:2];
  logic [14:0] dv_q   [0:DIV_STEPS][0:2];
  logic [31:0] dv_len [0:DIV_STEPS];
  side_t       dv_side[0:DIV_STEPS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_pr[0][i] <= (46'(sq_a[SQRT_STEPS][i]) << UNIT_SHIFT)
                   + 46'(sq_root[SQRT_STEPS][31:1]);
      dv_q[0][i]  <= '0;
    end
    dv_len[0]  <= sq_root[SQRT_STEPS];
    dv_side[0] <= sq_side[SQRT_STEPS];
  end

  // Restoring division, one quotient bit per stage, most significant first.
  // The quotient never exceeds 16384, so 15 bits cover it.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [46:0] dsr;
    assign dsr = {15'd0, dv_len[j]} << B;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic fit;
      logic [46:0] diff;
      assign fit  = ({1'b0, dv_pr[j][i]} >= dsr);
      assign diff = {1'b0, dv_pr[j][i]} - dsr;
      always_ff @(posedge clk) begin
        dv_pr[j+1][i] <= fit ? diff[45:0] : dv_pr[j][i];
        dv_q[j+1][i]  <= dv_q[j][i] | (15'(fit) << B);
      end
    end
    always_ff @(posedge clk) begin
      dv_len[j+1]  <= dv_len[j];
      dv_side[j+1] <= dv_side[j];
    end
  end

  // Result stage: restore signs, flip toward the original normal, and pass
  // the original normal through when the sum had zero length.
  logic signed [15:0] res [0:2];
  side_t              fin;
  assign fin = dv_side[DIV_STEPS];

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic signed [15:0] mag;
    assign mag    = $signed({1'b0, dv_q[DIV_STEPS][i]});
    assign res[i] = (fin.sgn[i] ^ fin.neg) ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (fin.zero) begin
      rsp.bent_x <= fin.nx;
      rsp.bent_y <= fin.ny;
      rsp.bent_z <= fin.nz;
    end else begin
      rsp.bent_x <= res[0];
      rsp.bent_y <= res[1];
      rsp.bent_z <= res[2];
    end
    rsp.degenerate <= fin.zero;
  end

  assign done = vld[LATENCY-1];

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for bump_normal_perturb: directed table, then random requests.
// Depends on bnp_pkg and the bump_normal_perturb RTL; needs nothing else.
module tb_top
  import bnp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bump_normal_perturb i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Bench copy of the gain registers, tracked as they are written.
  logic signed [15:0] gain [3];
  rsp_t               pending_normals [$];
  int                 errors = 0;

  // Integer square root, floor, by the digit-by-digit method.
  function automatic longint unsigned root_floor(longint unsigned q);
    longint unsigned rem, root, bit_w;
    rem = q;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > q) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Expected bent normal for one request under the current gains.
  function automatic rsp_t bend_normal(req_t r);
    longint n [3], t [3], s [3], res [3];
    longint m, dot;
    longint unsigned q, len, mag;
    rsp_t o;
    n[0] = r.normal_x; n[1] = r.normal_y; n[2] = r.normal_z;
    t[0] = longint'(r.texel_r) - 32768;
    t[1] = longint'(r.texel_g) - 32768;
    t[2] = longint'(r.texel_b) - 32768;
    for (int i = 0; i < 3; i++) s[i] = n[i] * (64'sd1 <<< NORM_ALIGN) + gain[i] * t[i];
    o = '0;
    if (s[0] == 0 && s[1] == 0 && s[2] == 0) begin
      // Zero-length sum: the original normal goes straight through.
      o.bent_x = r.normal_x; o.bent_y = r.normal_y; o.bent_z = r.normal_z;
      o.degenerate = 1'b1;
      return o;
    end
    dot = 0;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      dot += s[i] * n[i];
      if ((s[i] < 0 ? -s[i] : s[i]) > m) m = s[i] < 0 ? -s[i] : s[i];
    end
    // Scale up so the largest component reaches 2^30; direction is kept.
    while (m < (64'sd1 <<< 30)) begin
      m = m * 2;
      for (int i = 0; i < 3; i++) s[i] = s[i] * 2;
    end
    q = 0;
    for (int i = 0; i < 3; i++) q += longint'(s[i] < 0 ? -s[i] : s[i]) ** 2;
    len = root_floor(q);
    for (int i = 0; i < 3; i++) begin
      mag = longint'(s[i] < 0 ? -s[i] : s[i]) << UNIT_SHIFT;
      res[i] = longint'((mag + len / 2) / len);
      if (s[i] < 0) res[i] = -res[i];
      if (dot < 0) res[i] = -res[i];
    end
    o.bent_x = res[0][15:0]; o.bent_y = res[1][15:0]; o.bent_z = res[2][15:0];
    return o;
  endfunction

  // Results are sampled on the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_normals.size() == 0) begin
        $error("result with no request outstanding: %h", rsp);
        errors++;
      end else begin
        rsp_t e;
        e = pending_normals.pop_front();
        if (rsp.bent_x !== e.bent_x) begin
          $error("bent_x expected %0d actual %0d", e.bent_x, rsp.bent_x); errors++;
        end
        if (rsp.bent_y !== e.bent_y) begin
          $error("bent_y expected %0d actual %0d", e.bent_y, rsp.bent_y); errors++;
        end
        if (rsp.bent_z !== e.bent_z) begin
          $error("bent_z expected %0d actual %0d", e.bent_z, rsp.bent_z); errors++;
        end
        if (rsp.degenerate !== e.degenerate) begin
          $error("degenerate expected %0b actual %0b", e.degenerate, rsp.degenerate);
          errors++;
        end
      end
    end
  end

  // Register writes happen only while the pipeline is drained.
  task automatic write_gain(reg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    gain[idx] = val;
  endtask

  // Sends one request; the expectation is queued at the accepting edge.
  // The table's known field is optional: when set, run_table checks the table value against the prediction.
  task automatic send_request(req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    pending_normals.push_back(bend_normal(r));
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_normal_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  typedef struct {
    req_t req;
    logic known;
    rsp_t want;
  } vector_t;

  vector_t directed [$];

  function automatic req_t mk(int nx, int ny, int nz, int tr, int tg, int tb);
    req_t r;
    r.normal_x = 16'(nx); r.normal_y = 16'(ny); r.normal_z = 16'(nz);
    r.texel_r = 16'(tr); r.texel_g = 16'(tg); r.texel_b = 16'(tb);
    return r;
  endfunction

  function automatic rsp_t out(int x, int y, int z, bit d);
    rsp_t o;
    o.bent_x = 16'(x); o.bent_y = 16'(y); o.bent_z = 16'(z); o.degenerate = d;
    return o;
  endfunction

  task automatic run_table();
    foreach (directed[k]) begin
      if (directed[k].known) begin
        rsp_t p;
        p = bend_normal(directed[k].req);
        if (p !== directed[k].want) begin
          $error("table row %0d expected %h predicted %h", k, directed[k].want, p);
          errors++;
        end
      end
      send_request(directed[k].req);
      // A gap now and then so the strobe lands on varied phases.
      if ($urandom_range(3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end
    end
    drain_pipeline();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) gain[i] = GAIN_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset gains (1.0). Mid texel leaves the normal alone; zero sums are degenerate.
    directed.push_back('{mk(16384, 0, 0, 32768, 32768, 32768), 1, out(16384, 0, 0, 0)});
    directed.push_back('{mk(0, -16384, 0, 32768, 32768, 32768), 1, out(0, -16384, 0, 0)});
    directed.push_back('{mk(0, 0, 0, 32768, 32768, 32768), 1, out(0, 0, 0, 1)});
    directed.push_back('{mk(0, 0, 16384, 32768, 32768, 0), 1, out(0, 0, 16384, 1)});
    directed.push_back('{mk(-16384, 0, 0, 65535, 32768, 32768), 0, '0});
    directed.push_back('{mk(16384, 16384, 16384, 0, 0, 0), 0, '0});
    directed.push_back('{mk(-16384, -16384, -16384, 65535, 65535, 65535), 0, '0});
    // Texel fully opposes the normal: negative dot, result flipped back.
    directed.push_back('{mk(4096, 0, 0, 0, 32768, 32768), 0, '0});
    // Zero dot product with nonzero sum.
    directed.push_back('{mk(16384, 0, 0, 0, 65535, 32768), 1, out(0, 16384, 0, 0)});
    // Out-of-range normals, including raw 16-bit extremes.
    directed.push_back('{mk(-32768, 32767, 0, 32768, 32768, 32768), 0, '0});
    directed.push_back('{mk(32767, 0, -32768, 12345, 54321, 1), 0, '0});
    directed.push_back('{mk(1, 0, 0, 32768, 32768, 32768), 1, out(16384, 0, 0, 0)});
    run_table();

    // Extreme gains, every register, then a degenerate case where the gain is zero.
    write_gain(REG_GAIN_X, 16'h8000);
    write_gain(REG_GAIN_Y, 16'h7FFF);
    write_gain(REG_GAIN_Z, 16'h0000);
    directed.delete();
    directed.push_back('{mk(0, 0, 16384, 65535, 0, 65535), 0, '0});
    directed.push_back('{mk(0, 0, -16384, 0, 65535, 0), 0, '0});
    directed.push_back('{mk(-16384, 0, 0, 32769, 32768, 40000), 0, '0});
    directed.push_back('{mk(0, 0, 0, 32768, 32768, 0), 1, out(0, 0, 0, 1)});
    run_table();

    // Random phases: new gains each phase, bursts with random gaps except in every third phase.
    for (int ph = 0; ph < 10; ph++) begin
      int burst;
      for (int i = 0; i < 3; i++) begin
        logic [15:0] g;
        case ($urandom_range(4))
          0: g = 16'h8000;
          1: g = 16'h7FFF;
          2: g = 16'h1000;
          3: g = 16'(int'($urandom_range(8192)) - 4096);
          default: g = 16'($urandom);
        endcase
        write_gain(reg_idx_t'(i), g);
      end
      for (int n = 0; n < 50; n += burst) begin
        burst = $urandom_range(12, 1);
        for (int b = 0; b < burst; b++) begin
          req_t r;
          r.normal_x = rand_normal_comp();
          r.normal_y = rand_normal_comp();
          r.normal_z = rand_normal_comp();
          r.texel_r = 16'($urandom); r.texel_g = 16'($urandom); r.texel_b = 16'($urandom);
          case ($urandom_range(9))
            0: r.texel_r = 16'h8000;
            1: r = mk(0, 0, 0, 32768, 32768, 32768);
            2: r.normal_x = 16'($urandom);
            default: ;
          endcase
          send_request(r);
        end
        if (ph % 3 != 2) begin
          start <= 1'b0;
          repeat ($urandom_range(6, 1)) @(posedge clk);
        end
      end
      drain_pipeline();
    end

    if (errors == 0) begin
      $display("bump_normal_perturb: match");
    end else begin
      $display("bump_normal_perturb: mismatch");
    end
    $finish;
  end

  // Watchdog: ends the run as a mismatch if it never finishes.
  initial begin
    #5ms;
    $display("bump_normal_perturb: mismatch");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/bnp_pkg.sv
rtl/bump_normal_perturb.sv
bench/tb_top.sv
